// ===== rtl/tsis_pkg.sv =====
package tsis_pkg;

	// default buffer size limit, in bytes
	localparam int unsigned TSIS_MAX_BUF_BYTES = 65536;

	localparam int unsigned OFFSET_W = 16;
	localparam int unsigned LENGTH_W = 32;

	// result status codes
	localparam logic [1:0] STATUS_FOUND = 2'd0;
	localparam logic [1:0] STATUS_NONE  = 2'd1;
	localparam logic [1:0] STATUS_BAD   = 2'd2;

	// parser phase codes
	localparam logic [1:0] PH_TYPE = 2'd0;
	localparam logic [1:0] PH_LEN  = 2'd1;
	localparam logic [1:0] PH_SKIP = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} tsis_in_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [OFFSET_W-1:0] item_offset;
		logic [LENGTH_W-1:0] item_length;
	} tsis_out_t;

endpackage

// ===== rtl/tlv_sdnv_item_search_top.sv =====
// TLV item search over a byte stream. Each buffer arrives one byte per
// transaction on the byte channel, the final byte flagged by last_byte. Items
// are a type byte, an SDNV length (big-endian 7-bit groups, bit 7 = more) and
// a payload. The block looks for the first item with a nonzero length whose
// type equals the value written on the cfg channel, and on the final byte
// emits one result transaction: found (payload offset and length), not found,
// or malformed (missing or unterminated length, SDNV wider than 32 bits,
// skipped payload running past the end, or more than MAX_BUF_BYTES bytes
// before a decision). Rate is one byte per clock while byte_stall is low; a
// result passes through the input register and then the result register
// after its last byte is accepted, and is held there while result_stall is
// high. The byte channel stalls only when a last byte sits in the input
// register while the previous result is still held by a stalled consumer.
// Write cfg only while no buffer is in flight; cfg_ready is always high.
module tlv_sdnv_item_search_top
	import tsis_pkg::*;
#(
	parameter int unsigned MAX_BUF_BYTES = TSIS_MAX_BUF_BYTES
) (
	input  logic       clk,
	input  logic       arst_n,
	// byte channel
	input  logic       byte_valid,
	output logic       byte_stall,
	input  tsis_in_t   byte_item,
	// result channel
	output logic       result_valid,
	input  logic       result_stall,
	output tsis_out_t  result,
	// configuration: wanted item type
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	logic       valid_s1;
	tsis_in_t   item_s1;
	logic       slot_free;
	logic       step;
	logic       res_valid;
	tsis_out_t  res;
	logic [7:0] wanted_type_q;

	// non-last bytes always advance; a last byte needs room in the result reg
	assign step       = valid_s1 && (!item_s1.last_byte || slot_free);
	assign byte_stall = valid_s1 && !step;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_type_q <= '0;
		end else if (cfg_valid) begin
			wanted_type_q <= cfg_data;
		end
	end

	tsis_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_item  (byte_item),
		.hold       (byte_stall),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	tsis_parser #(
		.MAX_BUF_BYTES (MAX_BUF_BYTES)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.item        (item_s1),
		.wanted_type (wanted_type_q),
		.res_valid   (res_valid),
		.res         (res)
	);

	tsis_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_valid    (res_valid),
		.res          (res),
		.result_stall (result_stall),
		.slot_free    (slot_free),
		.result_valid (result_valid),
		.result       (result)
	);

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.status == STATUS_FOUND
			|| result.status == STATUS_NONE || result.status == STATUS_BAD)
		else $error("illegal result status");

	a_miss_zeroed: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != STATUS_FOUND
			|-> result.item_offset == '0 && result.item_length == '0)
		else $error("offset or length set without a match");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> item_s1.last_byte && result_valid && result_stall)
		else $error("byte channel stalled without a blocked result");

endmodule

// ===== rtl/tsis_in_stage.sv =====
module tsis_in_stage
	import tsis_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     byte_valid,
	input  tsis_in_t byte_item,
	input  logic     hold,
	output logic     valid_s1,
	output tsis_in_t item_s1
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!hold) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!hold && byte_valid) begin
			item_s1 <= byte_item;
		end
	end

endmodule

// ===== rtl/tsis_parser.sv =====
module tsis_parser
	import tsis_pkg::*;
#(
	parameter int unsigned MAX_BUF_BYTES = TSIS_MAX_BUF_BYTES
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  tsis_in_t   item,
	input  logic [7:0] wanted_type,
	output logic       res_valid,
	output tsis_out_t  res
);

	localparam int unsigned POS_W = $clog2(MAX_BUF_BYTES + 1);
	localparam int unsigned EXT_W = (POS_W > OFFSET_W) ? POS_W : OFFSET_W;
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_BUF_BYTES);

	logic [1:0]          phase_q, phase_n;
	logic [POS_W-1:0]    pos_q, pos_n;
	logic [7:0]          type_q, type_n;
	logic [LENGTH_W-1:0] acc_q, acc_n;
	logic [LENGTH_W-1:0] skip_q, skip_n;
	logic                done_q, done_n;
	logic [OFFSET_W-1:0] moff_q, moff_n;
	logic [LENGTH_W-1:0] mlen_q, mlen_n;
	logic [1:0]          outcome_q, outcome_n;

	logic [LENGTH_W-1:0] acc_shift;
	logic [LENGTH_W-1:0] skip_dec;
	logic [POS_W-1:0]    pos_inc;
	logic [1:0]          final_status;

	assign acc_shift = {acc_q[LENGTH_W-8:0], item.data_byte[6:0]};
	assign skip_dec  = skip_q - LENGTH_W'(skip_q != '0);
	assign pos_inc   = pos_q + POS_W'(1);

	always_comb begin
		phase_n   = phase_q;
		type_n    = type_q;
		acc_n     = acc_q;
		skip_n    = skip_q;
		done_n    = done_q;
		moff_n    = moff_q;
		mlen_n    = mlen_q;
		outcome_n = outcome_q;
		if (!done_q) begin
			if (pos_q >= POS_MAX) begin
				done_n    = 1'b1;
				outcome_n = STATUS_BAD;
			end else begin
				unique case (phase_q)
					PH_TYPE: begin
						type_n  = item.data_byte;
						acc_n   = '0;
						phase_n = PH_LEN;
					end
					PH_LEN: begin
						// another 7-bit group would push past 32 bits
						if (acc_q[LENGTH_W-1:LENGTH_W-7] != '0) begin
							acc_n     = '1;
							done_n    = 1'b1;
							outcome_n = STATUS_BAD;
						end else begin
							acc_n = acc_shift;
							if (!item.data_byte[7]) begin
								if (acc_shift == '0) begin
									phase_n = PH_TYPE;
								end else if (type_q == wanted_type) begin
									moff_n    = OFFSET_W'(EXT_W'(pos_inc));
									mlen_n    = acc_shift;
									done_n    = 1'b1;
									outcome_n = STATUS_FOUND;
								end else begin
									skip_n  = acc_shift;
									phase_n = PH_SKIP;
								end
							end
						end
					end
					PH_SKIP: begin
						skip_n = skip_dec;
						if (skip_dec == '0) begin
							phase_n = PH_TYPE;
						end
					end
					default: begin
						phase_n = PH_TYPE;
					end
				endcase
			end
		end
		pos_n = (pos_q < POS_MAX) ? pos_inc : pos_q;
	end

	// an undecided buffer ending between items is simply not found
	always_comb begin
		if (done_n) begin
			final_status = outcome_n;
		end else if (phase_n == PH_TYPE) begin
			final_status = STATUS_NONE;
		end else begin
			final_status = STATUS_BAD;
		end
	end

	assign res_valid = step && item.last_byte;

	always_comb begin
		res.status      = final_status;
		res.item_offset = (final_status == STATUS_FOUND) ? moff_n : '0;
		res.item_length = (final_status == STATUS_FOUND) ? mlen_n : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_TYPE;
			pos_q     <= '0;
			type_q    <= '0;
			acc_q     <= '0;
			skip_q    <= '0;
			done_q    <= 1'b0;
			moff_q    <= '0;
			mlen_q    <= '0;
			outcome_q <= STATUS_NONE;
		end else if (step) begin
			if (item.last_byte) begin
				phase_q   <= PH_TYPE;
				pos_q     <= '0;
				type_q    <= '0;
				acc_q     <= '0;
				skip_q    <= '0;
				done_q    <= 1'b0;
				moff_q    <= '0;
				mlen_q    <= '0;
				outcome_q <= STATUS_NONE;
			end else begin
				phase_q   <= phase_n;
				pos_q     <= pos_n;
				type_q    <= type_n;
				acc_q     <= acc_n;
				skip_q    <= skip_n;
				done_q    <= done_n;
				moff_q    <= moff_n;
				mlen_q    <= mlen_n;
				outcome_q <= outcome_n;
			end
		end
	end

	a_pos_sat: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_MAX)
		else $error("byte position beyond limit");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.last_byte |=> pos_q == '0 && !done_q && phase_q == PH_TYPE)
		else $error("buffer state not cleared after last byte");

	a_done_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		step && !item.last_byte && done_q |=> done_q && $stable(outcome_q)
			&& $stable(mlen_q))
		else $error("decision changed after being made");

endmodule

// ===== rtl/tsis_out_stage.sv =====
module tsis_out_stage
	import tsis_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      res_valid,
	input  tsis_out_t res,
	input  logic      result_stall,
	output logic      slot_free,
	output logic      result_valid,
	output tsis_out_t result
);

	logic      valid_q;
	tsis_out_t data_q;

	assign slot_free    = !valid_q || !result_stall;
	assign result_valid = valid_q;
	assign result       = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_valid) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			data_q <= res;
		end
	end

endmodule

// ===== verif/tlv_sdnv_item_search_top_tb.sv =====
module tlv_sdnv_item_search_top_tb;
	import tsis_pkg::*;

	localparam int HOLD_CYCLES = 300;
	// small buffer limit keeps the overlong case short
	localparam int unsigned BUF_LIMIT = 256;
	// largest accumulator that can take one more 7-bit group without overflow
	localparam logic [31:0] LEN_SHIFT_MAX = 32'h01FF_FFFF;

	logic      clk;
	logic      arst_n;
	logic      byte_valid;
	logic      byte_stall;
	tsis_in_t  byte_item;
	logic      result_valid;
	logic      result_stall;
	tsis_out_t result;
	logic      cfg_valid;
	logic      cfg_ready;
	logic [7:0] cfg_data;

	tlv_sdnv_item_search_top #(
		.MAX_BUF_BYTES (BUF_LIMIT)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_item    (byte_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	// search state mirrored from the byte stream
	logic [7:0]  want_type;
	logic [1:0]  scan_phase;
	int unsigned scan_pos;
	logic [7:0]  scan_type;
	logic [31:0] scan_len;
	logic [31:0] skip_left;
	logic        scan_decided;
	logic [31:0] hit_offset;
	logic [31:0] hit_length;
	logic [1:0]  scan_verdict;

	tsis_out_t   search_results_due[$];
	logic [7:0]  frame_bytes[$];
	int          fault_count;
	bit          idle_on;
	bit          hold_go;
	tsis_out_t   got_due;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic clear_scan();
		scan_phase   = PH_TYPE;
		scan_pos     = 0;
		scan_type    = '0;
		scan_len     = '0;
		skip_left    = '0;
		scan_decided = 1'b0;
		hit_offset   = '0;
		hit_length   = '0;
		scan_verdict = STATUS_NONE;
	endtask

	// advance the search by one accepted byte; the last byte yields one result
	task automatic search_step(input logic [7:0] b, input logic last);
		tsis_out_t res;
		if (!scan_decided) begin
			if (scan_pos >= BUF_LIMIT) begin
				scan_verdict = STATUS_BAD;
				scan_decided = 1'b1;
			end else if (scan_phase == PH_TYPE) begin
				scan_type  = b;
				scan_len   = '0;
				scan_phase = PH_LEN;
			end else if (scan_phase == PH_LEN) begin
				if (scan_len > LEN_SHIFT_MAX) begin
					// SDNV wider than 32 bits
					scan_verdict = STATUS_BAD;
					scan_decided = 1'b1;
				end else begin
					scan_len = {scan_len[24:0], b[6:0]};
					if (!b[7]) begin
						if (scan_len == '0) begin
							scan_phase = PH_TYPE;
						end else if (scan_type == want_type) begin
							hit_offset   = scan_pos + 1;
							hit_length   = scan_len;
							scan_verdict = STATUS_FOUND;
							scan_decided = 1'b1;
						end else begin
							skip_left  = scan_len;
							scan_phase = PH_SKIP;
						end
					end
				end
			end else begin
				if (skip_left != '0)
					skip_left = skip_left - 1;
				if (skip_left == '0)
					scan_phase = PH_TYPE;
			end
		end
		if (scan_pos < BUF_LIMIT)
			scan_pos++;
		if (last) begin
			if (!scan_decided)
				scan_verdict = (scan_phase == PH_TYPE) ? STATUS_NONE : STATUS_BAD;
			res.status      = scan_verdict;
			res.item_offset = (scan_verdict == STATUS_FOUND) ? hit_offset[15:0] : '0;
			res.item_length = (scan_verdict == STATUS_FOUND) ? hit_length : '0;
			search_results_due.push_back(res);
			clear_scan();
		end
	endtask

	// called and returns at a falling edge; valid stays up between bytes unless an idle gap is inserted
	task automatic send_byte(input logic [7:0] d, input logic last);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		byte_item  <= {d, last};
		byte_valid <= 1'b1;
		@(posedge clk);
		while (byte_stall) @(posedge clk);
		search_step(d, last);
		@(negedge clk);
	endtask

	task automatic send_frame();
		foreach (frame_bytes[i])
			send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
	endtask

	task automatic wait_drained();
		byte_valid <= 1'b0;
		@(negedge clk);
		while (search_results_due.size() != 0) @(negedge clk);
		// latency of the input and result registers, plus margin
		repeat (4) @(negedge clk);
	endtask

	task automatic set_wanted(input logic [7:0] v);
		wait_drained();
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		want_type = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic push_sdnv(input logic [31:0] v, input int pad);
		logic [6:0] grp[$];
		do begin
			grp.push_front(v[6:0]);
			v = v >> 7;
		end while (v != '0);
		repeat (pad) grp.push_front(7'd0);
		foreach (grp[i])
			frame_bytes.push_back({i != grp.size() - 1, grp[i]});
	endtask

	// mostly well-formed items with random content, sometimes broken at the end
	task automatic build_frame();
		int          n_items;
		int          r;
		int          n_pay;
		int          cut;
		logic [7:0]  t;
		logic [31:0] len;
		frame_bytes.delete();
		n_items = $urandom_range(0, 4);
		repeat (n_items) begin
			r = $urandom_range(0, 3);
			if (r < 2)
				t = want_type;
			else if (r == 2)
				t = want_type ^ (8'd1 << $urandom_range(0, 7));
			else
				t = 8'($urandom_range(0, 255));
			r = $urandom_range(0, 19);
			if (r < 3)
				len = '0;
			else if (r == 3)
				len = $urandom_range(128, 200);
			else if (r == 4)
				len = $urandom | 32'd1;
			else
				len = $urandom_range(1, 12);
			frame_bytes.push_back(t);
			push_sdnv(len, ($urandom_range(0, 5) == 0) ? $urandom_range(1, 9) : 0);
			n_pay = (len > 200) ? $urandom_range(0, 8) : int'(len);
			repeat (n_pay) frame_bytes.push_back(8'($urandom_range(0, 255)));
		end
		case ($urandom_range(0, 9))
			0: begin
				// truncate somewhere inside
				if (frame_bytes.size() > 1) begin
					cut = $urandom_range(1, frame_bytes.size() - 1);
					repeat (cut) void'(frame_bytes.pop_back());
				end
			end
			1: begin
				// five groups with a top group of 16 or more: needs over 32 bits
				frame_bytes.push_back(8'($urandom_range(0, 255)));
				frame_bytes.push_back(8'h80 | 8'($urandom_range(16, 127)));
				repeat (3) frame_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
				frame_bytes.push_back(8'($urandom_range(0, 127)));
			end
			2: frame_bytes.push_back(8'($urandom_range(0, 255)));
			3: begin
				frame_bytes.push_back(8'($urandom_range(0, 255)));
				frame_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
			end
			4: repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom_range(0, 255)));
			default: ;
		endcase
		if (frame_bytes.size() == 0)
			frame_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	// each special case once, type 0 wanted out of reset
	task automatic test_directed();
		frame_bytes = '{8'h00, 8'h03, 8'hAA};                   // match, rest ignored
		send_frame();
		frame_bytes = '{8'h05};                                 // no length
		send_frame();
		frame_bytes = '{8'h05, 8'h81};                          // SDNV never ends
		send_frame();
		frame_bytes = '{8'h00, 8'h00};                          // empty item of wanted type
		send_frame();
		frame_bytes = '{8'h07, 8'h05, 8'h11, 8'h22};            // payload cut short
		send_frame();
		frame_bytes = '{8'h07, 8'h01, 8'hFF, 8'h00, 8'h80, 8'h02}; // skip, then padded SDNV
		send_frame();
		frame_bytes = '{8'h00, 8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h7F}; // length 0xFFFFFFFF
		send_frame();
		frame_bytes = '{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F}; // over 32 bits
		send_frame();
	endtask

	// results held off while tiny buffers keep coming: input side must stall
	task automatic test_stall_pressure();
		idle_on = 1'b0;
		hold_go = 1'b1;
		repeat (16) begin
			frame_bytes.delete();
			frame_bytes.push_back($urandom_range(0, 1) ? want_type : 8'($urandom_range(0, 255)));
			frame_bytes.push_back(8'h01);
			frame_bytes.push_back(8'($urandom_range(0, 255)));
			send_frame();
		end
		wait_drained();
	endtask

	task automatic test_random_buffers(input logic [7:0] want, input int n_bytes,
			input int n_frames, input bit idle);
		int sent;
		int frames;
		sent   = 0;
		frames = 0;
		set_wanted(want);
		idle_on = idle;
		while (sent < n_bytes || frames < n_frames) begin
			build_frame();
			sent += frame_bytes.size();
			frames++;
			send_frame();
		end
	endtask

	task automatic test_noise();
		idle_on = 1'b1;
		repeat (40) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
		send_byte(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// sender stops until every result is back, then carries on
	task automatic test_drain_pause();
		set_wanted(8'($urandom_range(1, 254)));
		idle_on = 1'b1;
		repeat (2) begin
			build_frame();
			send_frame();
		end
		wait_drained();
		repeat (2) begin
			build_frame();
			send_frame();
		end
	endtask

	// skipped payload still running at the buffer size limit
	task automatic test_overlong_buffer();
		set_wanted(8'h11);
		idle_on = 1'b0;
		frame_bytes.delete();
		frame_bytes.push_back(8'h22);
		push_sdnv(32'(BUF_LIMIT), 0);
		while (frame_bytes.size() < BUF_LIMIT + 4)
			frame_bytes.push_back(8'($urandom_range(0, 255)));
		send_frame();
	endtask

	// result-side stall: random bursts, plus one long hold-off on request
	initial begin
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_go) begin
				hold_go = 1'b0;
				result_stall <= 1'b1;
				for (int k = 0; k < HOLD_CYCLES; k++) @(negedge clk);
				result_stall <= 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(negedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	// compare every result transaction against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (search_results_due.size() == 0) begin
				$error("unexpected result: status %0d offset %0d length %0d",
					result.status, result.item_offset, result.item_length);
				fault_count++;
			end else begin
				got_due = search_results_due.pop_front();
				if (result.status !== got_due.status) begin
					$error("status: expected %0d, got %0d", got_due.status, result.status);
					fault_count++;
				end
				if (result.item_offset !== got_due.item_offset) begin
					$error("item_offset: expected %0d, got %0d",
						got_due.item_offset, result.item_offset);
					fault_count++;
				end
				if (result.item_length !== got_due.item_length) begin
					$error("item_length: expected %0d, got %0d",
						got_due.item_length, result.item_length);
					fault_count++;
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("FAIL tlv_sdnv_item_search_top");
		$finish;
	end

	initial begin
		arst_n      = 1'b0;
		byte_valid  = 1'b0;
		byte_item   = '0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		fault_count = 0;
		idle_on     = 1'b0;
		hold_go     = 1'b0;
		want_type   = '0;
		clear_scan();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_stall_pressure();
		test_random_buffers(8'hFF, 50, 2, 1'b1);
		test_noise();
		test_drain_pause();
		test_overlong_buffer();
		test_random_buffers(8'($urandom_range(0, 255)), 50, 2, 1'b1);
		test_random_buffers(8'h00, 50, 2, 1'b1);
		test_random_buffers(8'($urandom_range(0, 255)), 50, 2, 1'b0);

		wait_drained();
		repeat (10) @(negedge clk);
		if (fault_count == 0 && search_results_due.size() == 0)
			$display("PASS tlv_sdnv_item_search_top");
		else
			$display("FAIL tlv_sdnv_item_search_top");
		$finish;
	end

endmodule

// ===== tlv_sdnv_item_search_top.f =====
rtl/tsis_pkg.sv
rtl/tsis_in_stage.sv
rtl/tsis_parser.sv
rtl/tsis_out_stage.sv
rtl/tlv_sdnv_item_search_top.sv
verif/tlv_sdnv_item_search_top_tb.sv
